FILE: rtl/mcpid_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the multi-channel pid speed loop
// no dependencies; used by multi_channel_pid_speed_loop_core
package mcpid_pkg;

	localparam int CHANNELS_DEF = 4;

	localparam int CH_W    = 2;
	localparam int SPEED_W = 16;
	localparam int GAIN_W  = 16;
	localparam int DUTY_W  = 8;
	localparam int ERR_W   = 18;
	localparam int INTEG_W = 32;
	localparam int PROD_W  = 36;
	localparam int CFG_IDX_W = 2;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP = 2'd0,
		REG_KI = 2'd1,
		REG_KD = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0]           channel;
		logic signed [SPEED_W-1:0] target_speed;
		logic signed [SPEED_W-1:0] measured_speed;
	} req_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel_out;
		logic [DUTY_W-1:0] pwm_duty;
		logic              direction;
	} res_t;

endpackage

FILE: rtl/multi_channel_pid_speed_loop_core.sv
`timescale 1ns / 1ps
// multi-channel pid speed loop with integral saturation and duty clamp
// depends on mcpid_pkg for request/result structs and constants
// a request passes input reg, product reg and result reg before its result is valid
// throughput: one request per cycle if not stalled; per-channel state is updated where used
// reset: clears gains, all integrals and previous errors, and every valid flag
module multi_channel_pid_speed_loop_core #(
	parameter int CHANNELS = mcpid_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mcpid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcpid_pkg::GAIN_W-1:0]        cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  mcpid_pkg::req_t                     req,
	output logic                                res_valid,
	input  logic                                res_stall,
	output mcpid_pkg::res_t                     res
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CMP_W = (IDX_W > mcpid_pkg::CH_W ? IDX_W : mcpid_pkg::CH_W) + 1;
	localparam logic [CMP_W-1:0] CH_LIMIT = CMP_W'(CHANNELS);

	logic [mcpid_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;

	logic signed [mcpid_pkg::ERR_W-1:0]   prev_err_q [CHANNELS];
	logic signed [mcpid_pkg::INTEG_W-1:0] integ_q    [CHANNELS];

	// stage 1: captured request
	logic            valid_s1;
	mcpid_pkg::req_t req_s1;

	// stage 2: products
	logic                                  valid_s2;
	logic [mcpid_pkg::CH_W-1:0]            ch_s2;
	logic [IDX_W-1:0]                      idx_s2;
	logic                                  ok_s2;
	logic                                  dir_s2;
	logic signed [mcpid_pkg::PROD_W-1:0]   p_s2, iinc_s2, d_s2;

	logic            res_valid_q;
	mcpid_pkg::res_t res_q;

	logic en_out, en_s2, en_s1;

	assign en_out    = !res_valid_q || !res_stall;
	assign en_s2     = !valid_s2 || en_out;
	assign en_s1     = !valid_s1 || en_s2;
	assign req_stall = !en_s1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mcpid_pkg::REG_KP: kp_q <= cfg_data;
				mcpid_pkg::REG_KI: ki_q <= cfg_data;
				mcpid_pkg::REG_KD: kd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 logic: error and gain products
	logic signed [mcpid_pkg::SPEED_W:0]   tgt_w, meas_w, tgt_mag, meas_mag;
	logic signed [mcpid_pkg::ERR_W-1:0]   err_c, prev_c;
	logic signed [mcpid_pkg::ERR_W:0]     esum_c, edif_c;
	logic [IDX_W-1:0]                     idx_s1;
	logic                                 ok_s1;
	logic                                 dir_s1;
	logic signed [mcpid_pkg::PROD_W-1:0]  p_c, iinc_c, d_c;

	assign tgt_w    = (mcpid_pkg::SPEED_W+1)'(req_s1.target_speed);
	assign meas_w   = (mcpid_pkg::SPEED_W+1)'(req_s1.measured_speed);
	assign tgt_mag  = tgt_w[mcpid_pkg::SPEED_W] ? -tgt_w : tgt_w;
	assign meas_mag = meas_w[mcpid_pkg::SPEED_W] ? -meas_w : meas_w;
	assign err_c    = mcpid_pkg::ERR_W'(tgt_mag) - mcpid_pkg::ERR_W'(meas_mag);
	assign idx_s1   = IDX_W'(req_s1.channel);
	assign ok_s1    = CMP_W'(req_s1.channel) < CH_LIMIT;
	assign prev_c   = prev_err_q[idx_s1];
	assign esum_c   = (mcpid_pkg::ERR_W+1)'(err_c) + (mcpid_pkg::ERR_W+1)'(prev_c);
	assign edif_c   = (mcpid_pkg::ERR_W+1)'(err_c) - (mcpid_pkg::ERR_W+1)'(prev_c);
	assign dir_s1   = !req_s1.target_speed[mcpid_pkg::SPEED_W-1] && (|req_s1.target_speed);

	assign p_c    = mcpid_pkg::PROD_W'($signed({1'b0, kp_q})) * mcpid_pkg::PROD_W'(err_c);
	assign iinc_c = mcpid_pkg::PROD_W'($signed({1'b0, ki_q})) * mcpid_pkg::PROD_W'(esum_c);
	assign d_c    = mcpid_pkg::PROD_W'($signed({1'b0, kd_q})) * mcpid_pkg::PROD_W'(edif_c);

	// stage 2 logic: integral update and duty clamp
	localparam int ISUM_W = mcpid_pkg::PROD_W + 1;
	localparam int SUM_W  = mcpid_pkg::PROD_W + 2;

	logic signed [ISUM_W-1:0]              isum_c;
	logic signed [mcpid_pkg::INTEG_W-1:0]  isat_c, integ_new_c;
	logic signed [SUM_W-1:0]               sum_c;
	logic [mcpid_pkg::DUTY_W-1:0]          duty_c;

	assign isum_c = ISUM_W'(integ_q[idx_s2]) + ISUM_W'(iinc_s2);

	always_comb begin
		if (!isum_c[ISUM_W-1] && (|isum_c[ISUM_W-2:mcpid_pkg::INTEG_W-1])) begin
			isat_c = {1'b0, {(mcpid_pkg::INTEG_W-1){1'b1}}};
		end else if (isum_c[ISUM_W-1] && !(&isum_c[ISUM_W-2:mcpid_pkg::INTEG_W-1])) begin
			isat_c = {1'b1, {(mcpid_pkg::INTEG_W-1){1'b0}}};
		end else begin
			isat_c = isum_c[mcpid_pkg::INTEG_W-1:0];
		end
	end

	assign integ_new_c = (ki_q == '0) ? '0 : isat_c;
	assign sum_c = SUM_W'(p_s2) + SUM_W'(integ_new_c) + SUM_W'(d_s2);

	always_comb begin
		if (!ok_s2 || sum_c[SUM_W-1]) begin
			duty_c = '0;
		end else if (|sum_c[SUM_W-2:mcpid_pkg::DUTY_W+8]) begin
			duty_c = mcpid_pkg::DUTY_MAX;
		end else begin
			duty_c = sum_c[mcpid_pkg::DUTY_W+7:8];
		end
	end

	// pipeline control and per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				prev_err_q[i] <= '0;
				integ_q[i]    <= '0;
			end
		end else begin
			if (en_s1) begin
				valid_s1 <= req_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				res_valid_q <= valid_s2;
			end
			if (valid_s1 && en_s2 && ok_s1) begin
				prev_err_q[idx_s1] <= err_c;
			end
			if (valid_s2 && en_out && ok_s2) begin
				integ_q[idx_s2] <= integ_new_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req_valid) begin
			req_s1 <= req;
		end
		if (en_s2 && valid_s1) begin
			ch_s2   <= req_s1.channel;
			idx_s2  <= idx_s1;
			ok_s2   <= ok_s1;
			dir_s2  <= dir_s1;
			p_s2    <= p_c;
			iinc_s2 <= iinc_c;
			d_s2    <= d_c;
		end
		if (en_out && valid_s2) begin
			res_q.channel_out <= ch_s2;
			res_q.pwm_duty    <= duty_c;
			res_q.direction   <= dir_s2;
		end
	end

	// checks
	a_bad_channel_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (CMP_W'(res.channel_out) >= CH_LIMIT)) |-> (res.pwm_duty == '0))
		else $error("out-of-range channel produced nonzero duty");

	a_ki_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en_out && ok_s2 && (ki_q == '0)) |=> (integ_q[$past(idx_s2)] == '0))
		else $error("integral not cleared with zero ki");

	a_empty_front_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !req_stall)
		else $error("stall raised with empty input stage");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench for multi_channel_pid_speed_loop_core: directed and random speed requests,
// a built-in pid model predicts every duty result, and results are checked in order
// depends on mcpid_pkg and the core rtl only
module testbench;

	localparam int N_CH = mcpid_pkg::CHANNELS_DEF;
	localparam logic [mcpid_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int SQUEEZE_CYCLES = 150;
	localparam int MAX_PRINTED = 50;

	class pid_scoreboard;
		bit [mcpid_pkg::GAIN_W-1:0] kp_q8, ki_q8, kd_q8;
		longint integ_acc[N_CH];
		longint prev_err[N_CH];
		mcpid_pkg::res_t duty_queue[$];
		int fail_count;

		function void set_gain(logic [mcpid_pkg::CFG_IDX_W-1:0] idx,
			bit [mcpid_pkg::GAIN_W-1:0] v);
			case (idx)
				mcpid_pkg::REG_KP: kp_q8 = v;
				mcpid_pkg::REG_KI: ki_q8 = v;
				mcpid_pkg::REG_KD: kd_q8 = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return duty_queue.size();
		endfunction

		function void note_request(mcpid_pkg::req_t r);
			longint tgt, meas, err, p, d, acc, sum, whole;
			mcpid_pkg::res_t e;
			tgt = longint'($signed(r.target_speed));
			meas = longint'($signed(r.measured_speed));
			e.channel_out = r.channel;
			e.direction = (tgt > 0);
			e.pwm_duty = '0;
			if (int'(r.channel) < N_CH) begin
				err = (tgt < 0 ? -tgt : tgt) - (meas < 0 ? -meas : meas);
				p = longint'(kp_q8) * err;
				d = longint'(kd_q8) * (err - prev_err[r.channel]);
				if (ki_q8 != 0) begin
					acc = integ_acc[r.channel] + longint'(ki_q8) * (err + prev_err[r.channel]);
					if (acc > 64'sd2147483647)
						acc = 64'sd2147483647;
					else if (acc < -64'sd2147483648)
						acc = -64'sd2147483648;
					integ_acc[r.channel] = acc;
				end else begin
					integ_acc[r.channel] = 0;
				end
				prev_err[r.channel] = err;
				sum = p + integ_acc[r.channel] + d;
				if (sum >= 0) begin
					whole = sum >>> 8;
					e.pwm_duty = (whole > 255) ? mcpid_pkg::DUTY_MAX
						: mcpid_pkg::DUTY_W'(whole);
				end
			end
			duty_queue.push_back(e);
		endfunction

		task report(string msg);
			if (fail_count < MAX_PRINTED)
				$display("mismatch at %0t: %s", $realtime, msg);
			fail_count++;
		endtask

		task check_result(mcpid_pkg::res_t got);
			mcpid_pkg::res_t want;
			if (duty_queue.size() == 0) begin
				report($sformatf("result with nothing pending: ch %0d duty %0d dir %0d",
					got.channel_out, got.pwm_duty, got.direction));
			end else begin
				want = duty_queue.pop_front();
				if (got.channel_out !== want.channel_out)
					report($sformatf("channel_out %0d, want %0d",
						got.channel_out, want.channel_out));
				if (got.pwm_duty !== want.pwm_duty)
					report($sformatf("pwm_duty %0d, want %0d (ch %0d)",
						got.pwm_duty, want.pwm_duty, want.channel_out));
				if (got.direction !== want.direction)
					report($sformatf("direction %0d, want %0d (ch %0d)",
						got.direction, want.direction, want.channel_out));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mcpid_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mcpid_pkg::GAIN_W-1:0] cfg_data;
	logic req_valid;
	logic req_stall;
	mcpid_pkg::req_t req;
	logic res_valid;
	logic res_stall;
	mcpid_pkg::res_t res;

	pid_scoreboard sb = new();
	int unsigned cycles;
	bit squeeze_req;
	bit squeeze_done;
	int squeeze_left;
	int hold_left;
	int free_left;

	multi_channel_pid_speed_loop_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (res_valid && !res_stall)
			sb.check_result(res);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit [mcpid_pkg::GAIN_W-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		else if (r < 30)
			return '1;
		else if (r < 70)
			return mcpid_pkg::GAIN_W'($urandom_range(1, 16'h0400));
		return mcpid_pkg::GAIN_W'($urandom());
	endfunction

	function automatic mcpid_pkg::req_t make_req(int ch, int tgt, int meas);
		mcpid_pkg::req_t r;
		r.channel = mcpid_pkg::CH_W'(ch);
		r.target_speed = mcpid_pkg::SPEED_W'(tgt);
		r.measured_speed = mcpid_pkg::SPEED_W'(meas);
		return r;
	endfunction

	function automatic mcpid_pkg::req_t rand_request();
		int r, tgt, mag;
		int extremes[6] = '{-32768, -32767, -1, 0, 1, 32767};
		r = $urandom_range(0, 99);
		if (r < 60) begin
			tgt = $urandom_range(0, 3000);
			if ($urandom_range(0, 1))
				tgt = -tgt;
			mag = (tgt < 0 ? -tgt : tgt) + $urandom_range(0, 400) - 200;
			if (mag < 0)
				mag = 0;
			if ($urandom_range(0, 1))
				mag = -mag;
			return make_req($urandom_range(0, N_CH - 1), tgt, mag);
		end else if (r < 85) begin
			return make_req($urandom_range(0, 3), $urandom(), $urandom());
		end
		return make_req($urandom_range(0, 3), extremes[$urandom_range(0, 5)],
			extremes[$urandom_range(0, 5)]);
	endfunction

	// receiver: random stalls, quiet stretches, and one long hold-off on request
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_left > 0) begin
				squeeze_left--;
				res_stall <= 1'b1;
				if (squeeze_left == 0)
					squeeze_done = 1'b1;
			end else if (squeeze_req && !squeeze_done) begin
				squeeze_left = SQUEEZE_CYCLES;
				res_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				res_stall <= 1'b0;
			end else begin
				hold_left = pick_gap();
				free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 12);
				res_stall <= 1'b0;
			end
		end
	end

	task wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_gains(bit [mcpid_pkg::GAIN_W-1:0] kp, bit [mcpid_pkg::GAIN_W-1:0] ki,
		bit [mcpid_pkg::GAIN_W-1:0] kd);
		req_valid <= 1'b0;
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= mcpid_pkg::REG_KP;
		cfg_data <= kp;
		@(posedge clk);
		sb.set_gain(mcpid_pkg::REG_KP, kp);
		cfg_index <= mcpid_pkg::REG_KI;
		cfg_data <= ki;
		@(posedge clk);
		sb.set_gain(mcpid_pkg::REG_KI, ki);
		cfg_index <= mcpid_pkg::REG_KD;
		cfg_data <= kd;
		@(posedge clk);
		sb.set_gain(mcpid_pkg::REG_KD, kd);
		// writes to the spare index must leave every gain alone
		cfg_index <= REG_UNUSED;
		cfg_data <= mcpid_pkg::GAIN_W'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task send_request(mcpid_pkg::req_t item, int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(item);
	endtask

	initial begin
		int phase, n;
		cfg_we = 1'b0;
		cfg_index = mcpid_pkg::REG_KP;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// unity-ish gains, field extremes and sign handling
		write_gains(16'h0100, 16'h0010, 16'h0080);
		send_request(make_req(0, 100, 0), 0);
		send_request(make_req(0, 100, 50), 1);
		send_request(make_req(0, -100, -100), 0);
		send_request(make_req(0, 0, 0), 2);
		send_request(make_req(0, 32767, 0), 0);
		send_request(make_req(0, -32768, 0), 0);
		send_request(make_req(0, 0, -32768), 3);
		send_request(make_req(1, 1, -1), 0);
		send_request(make_req(2, -1, 2), 0);
		send_request(make_req(3, 200, 199), 1);
		send_request(make_req(3, 200, 300), 0);
		send_request(make_req(1, -32768, -32768), 0);

		// full-scale gains drive the integral into both saturation limits
		write_gains('1, '1, '1);
		repeat (3) send_request(make_req(0, -32768, 0), 0);
		repeat (3) send_request(make_req(1, 0, -32768), 0);
		send_request(make_req(2, 32767, 32767), 0);
		send_request(make_req(3, 1, 0), 0);

		// zero integral gain clears the accumulated integral
		write_gains(16'h0100, 16'h0000, 16'h0000);
		send_request(make_req(0, 10, 0), 0);
		send_request(make_req(1, 10, 0), 0);

		for (phase = 0; phase < 8; phase++) begin
			write_gains(pick_gain(), (phase == 3) ? 16'h0000 : pick_gain(), pick_gain());
			if (phase == 4)
				squeeze_req = 1'b1;
			for (n = 0; n < 150; n++)
				send_request(rand_request(), (phase == 4 && n < 40) ? 0 : pick_gap());
		end
		req_valid <= 1'b0;

		wait_idle();
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
